FILE: rtl/assert_macros.svh
// Assertion macros used by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define BOXF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("filter assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define BOXF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("filter assertion failed");

`endif

FILE: rtl/boxf_pkg.sv
// Package with the constants and types of the box blur and edge filter.
`timescale 1ns / 1ps
`default_nettype none
package boxf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 7;

  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;
  localparam int SIZE_W   = 11;
  localparam int RADIUS_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = SIZE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_RADIUS       = 2'd2,
    REG_MODE         = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic {
    MODE_BLUR = 1'b0,
    MODE_EDGE = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MULT,
    ST_START,
    ST_READ,
    ST_LAST,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/box_blur_and_edge_filter.sv
// Top level of the streaming box blur and edge filter.
// A word that yields a result passes through setup, the offset multiply, the window start, one read
// per window pixel inside the frame, the final accumulate, the serial divide and the output state,
// which waits while the output is stalled. One word at a time: such a word holds the input until its
// result is loaded, set by the single store read port and the serial divider; other words do not.
// Reset (synchronous, rst_n low) clears positions, counters and control registers and loads the
// configuration defaults; the line store keeps whatever it held and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module box_blur_and_edge_filter
  import boxf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write channel.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Pixel input channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_operation,
  input  wire logic [CH_W-1:0]       in_red_in,
  input  wire logic [CH_W-1:0]       in_green_in,
  input  wire logic [CH_W-1:0]       in_blue_in,
  // Result channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CH_W-1:0]            out_red_out,
  output logic [CH_W-1:0]            out_green_out,
  output logic [CH_W-1:0]            out_blue_out,
  output logic                       out_frame_last
);

  // The line store holds 2*MAX_RADIUS+1 rows as a circular buffer.
  localparam int Depth = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam int PW    = $clog2(Depth + 1);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int BKW   = RW + XW + 1;
  localparam int WinMax = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNTW  = $clog2(WinMax + 1);
  localparam int SUMW  = $clog2(WinMax * 255 + 1);
  localparam int DCW   = $clog2(SUMW + 1);

  // Configuration registers.
  logic [SIZE_W-1:0]   frame_width_r, frame_height_r;
  logic [RADIUS_W-1:0] radius_r;
  logic                mode_r;

  // Control state.
  state_t          state_r, state_nxt;
  logic [YW-1:0]   in_row_r, in_row_nxt;
  logic [XW-1:0]   in_col_r, in_col_nxt;
  logic [YW-1:0]   out_row_r, out_row_nxt;
  logic [XW-1:0]   out_col_r, out_col_nxt;
  logic [AW-1:0]   rd_addr_r, rd_addr_nxt;
  logic [PW-1:0]   pending_r, pending_nxt;
  logic            acc_v_r, acc_v_nxt;
  logic [DCW-1:0]  div_cnt_r, div_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Window walk and arithmetic.
  logic [YW-1:0]   orow_r, orow_nxt, r0_r, r0_nxt, r1_r, r1_nxt, x_r, x_nxt;
  logic [XW-1:0]   ocol_r, ocol_nxt, c0_r, c0_nxt, c1_r, c1_nxt, y_r, y_nxt;
  logic [AW-1:0]   back_r, back_nxt, addr_r, addr_nxt, row_base_r, row_base_nxt;
  logic [PIX_W-1:0] centre_r, centre_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [SUMW-1:0] sum_r [3];
  logic [SUMW-1:0] sum_nxt [3];
  logic [CNTW-1:0] rem_r [3];
  logic [CNTW-1:0] rem_nxt [3];
  logic [CH_W-1:0] res_r [3];
  logic [CH_W-1:0] res_nxt [3];
  logic            last_r, last_nxt;

  // Line store.
  logic [PIX_W-1:0] store_mem [Depth];
  logic [PIX_W-1:0] rd_data_r;
  logic [AW-1:0]    rd_sel;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;
  logic [PIX_W-1:0] wr_data;

  // Effective sizes: zero and oversize values are saturated.
  logic [XW-1:0]  w_eff;
  logic [YW-1:0]  h_eff;
  logic [RW-1:0]  r_eff;
  logic [BKW-1:0] r_ext, w_ext, delay;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = XW'(1);
    end else if (int'(frame_width_r) > MAX_WIDTH) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = YW'(1);
    end else if (int'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = YW'(MAX_HEIGHT);
    end else begin
      h_eff = YW'(frame_height_r);
    end
    if (int'(radius_r) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(radius_r);
    end
    r_ext = BKW'(r_eff);
    w_ext = BKW'(w_eff);
    // Number of later pixels a result waits for: radius rows plus radius pixels.
    delay = r_ext * w_ext + r_ext;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= SIZE_W'(DEF_MAX_WIDTH);
      frame_height_r <= SIZE_W'(DEF_MAX_HEIGHT);
      radius_r       <= RADIUS_W'(2);
      mode_r         <= MODE_BLUR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_RADIUS:       radius_r       <= cfg_data[RADIUS_W-1:0];
        REG_MODE:         mode_r         <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Combinational helpers for the main sequencer.
  logic [AW:0]     wa_sum, start_sum, base_sum;
  logic [YW:0]     row_hi;
  logic [XW:0]     col_hi;
  logic [YW-1:0]   in_row_c, orow_c;
  logic [XW-1:0]   in_col_c, ocol_c;
  logic [BKW-1:0]  dr_ext, dc_ext, back_full;
  logic [CNTW:0]   rem_sh;
  logic            ge;
  logic [CH_W-1:0] mean, ctr, diff;
  logic            slot_free;
  logic            accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign wr_data   = {in_red_in, in_green_in, in_blue_in};

  always_comb begin
    state_nxt     = state_r;
    in_row_nxt    = in_row_r;
    in_col_nxt    = in_col_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    rd_addr_nxt   = rd_addr_r;
    pending_nxt   = pending_r;
    acc_v_nxt     = 1'b0;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    back_nxt      = back_r;
    addr_nxt      = addr_r;
    row_base_nxt  = row_base_r;
    centre_nxt    = centre_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    for (int k = 0; k < 3; k++) begin
      sum_nxt[k] = sum_r[k];
      rem_nxt[k] = rem_r[k];
      res_nxt[k] = res_r[k];
    end
    wr_en   = 1'b0;
    rd_sel  = addr_r;
    rem_sh  = '0;
    ge      = 1'b0;
    mean    = '0;
    ctr     = '0;
    diff    = '0;
    row_hi  = '0;
    col_hi  = '0;
    dr_ext  = '0;
    dc_ext  = '0;
    back_full = '0;

    // The new pixel goes behind the pending ones in the circular store.
    wa_sum  = {1'b0, rd_addr_r} + (AW+1)'(pending_r);
    if (wa_sum >= (AW+1)'(Depth)) begin
      wa_sum = wa_sum - (AW+1)'(Depth);
    end
    wr_addr = wa_sum[AW-1:0];

    in_row_c = (in_row_r >= h_eff) ? h_eff - YW'(1) : in_row_r;
    in_col_c = (in_col_r >= w_eff) ? w_eff - XW'(1) : in_col_r;
    orow_c   = (out_row_r >= h_eff) ? h_eff - YW'(1) : out_row_r;
    ocol_c   = (out_col_r >= w_eff) ? w_eff - XW'(1) : out_col_r;

    // First address of the window, counted back from the centre.
    start_sum = {1'b0, rd_addr_r} + (AW+1)'(Depth) - {1'b0, back_r};
    if (start_sum >= (AW+1)'(Depth)) begin
      start_sum = start_sum - (AW+1)'(Depth);
    end
    base_sum = {1'b0, row_base_r} + (AW+1)'(w_eff);
    if (base_sum >= (AW+1)'(Depth)) begin
      base_sum = base_sum - (AW+1)'(Depth);
    end

    // Accumulate the word read in the previous cycle.
    if (acc_v_r) begin
      sum_nxt[0] = sum_r[0] + SUMW'(rd_data_r[2*CH_W +: CH_W]);
      sum_nxt[1] = sum_r[1] + SUMW'(rd_data_r[CH_W +: CH_W]);
      sum_nxt[2] = sum_r[2] + SUMW'(rd_data_r[0 +: CH_W]);
      cnt_nxt    = cnt_r + CNTW'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (op_t'(in_operation) == OP_PIXEL) begin
            wr_en = 1'b1;
            if (in_col_c == w_eff - XW'(1)) begin
              in_col_nxt = '0;
              in_row_nxt = (in_row_c == h_eff - YW'(1)) ? '0 : in_row_c + YW'(1);
            end else begin
              in_col_nxt = in_col_c + XW'(1);
              in_row_nxt = in_row_c;
            end
            if (pending_r < PW'(Depth)) begin
              pending_nxt = pending_r + PW'(1);
            end
            if (32'(pending_nxt) > 32'(delay)) begin
              state_nxt = ST_SETUP;
            end
          end else if (pending_r != '0) begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        // Clip the window to the frame around the clamped output position.
        orow_nxt = orow_c;
        ocol_nxt = ocol_c;
        r0_nxt   = (orow_c > YW'(r_eff)) ? orow_c - YW'(r_eff) : '0;
        c0_nxt   = (ocol_c > XW'(r_eff)) ? ocol_c - XW'(r_eff) : '0;
        row_hi   = {1'b0, orow_c} + (YW+1)'(r_eff);
        col_hi   = {1'b0, ocol_c} + (XW+1)'(r_eff);
        r1_nxt   = (row_hi >= {1'b0, h_eff}) ? h_eff - YW'(1) : row_hi[YW-1:0];
        c1_nxt   = (col_hi >= {1'b0, w_eff}) ? w_eff - XW'(1) : col_hi[XW-1:0];
        last_nxt = (orow_c == h_eff - YW'(1)) && (ocol_c == w_eff - XW'(1));
        state_nxt = ST_MULT;
      end
      ST_MULT: begin
        dr_ext    = BKW'(orow_r - r0_r);
        dc_ext    = BKW'(ocol_r - c0_r);
        back_full = dr_ext * w_ext + dc_ext;
        back_nxt  = AW'(back_full);
        rd_sel    = rd_addr_r;
        state_nxt = ST_START;
      end
      ST_START: begin
        centre_nxt   = rd_data_r;
        addr_nxt     = start_sum[AW-1:0];
        row_base_nxt = start_sum[AW-1:0];
        x_nxt        = r0_r;
        y_nxt        = c0_r;
        cnt_nxt      = '0;
        for (int k = 0; k < 3; k++) begin
          sum_nxt[k] = '0;
        end
        state_nxt = ST_READ;
      end
      ST_READ: begin
        rd_sel    = addr_r;
        acc_v_nxt = 1'b1;
        if (y_r == c1_r) begin
          if (x_r == r1_r) begin
            state_nxt = ST_LAST;
          end else begin
            x_nxt        = x_r + YW'(1);
            y_nxt        = c0_r;
            row_base_nxt = base_sum[AW-1:0];
            addr_nxt     = base_sum[AW-1:0];
          end
        end else begin
          y_nxt    = y_r + XW'(1);
          addr_nxt = (addr_r == AW'(Depth - 1)) ? '0 : addr_r + AW'(1);
        end
      end
      ST_LAST: begin
        for (int k = 0; k < 3; k++) begin
          rem_nxt[k] = '0;
        end
        div_cnt_nxt = DCW'(SUMW);
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        // One quotient bit per cycle for each channel.
        for (int k = 0; k < 3; k++) begin
          rem_sh = {rem_r[k], sum_r[k][SUMW-1]};
          ge     = (rem_sh >= {1'b0, cnt_r});
          rem_nxt[k] = ge ? CNTW'(rem_sh - {1'b0, cnt_r}) : rem_sh[CNTW-1:0];
          sum_nxt[k] = {sum_r[k][SUMW-2:0], ge};
        end
        div_cnt_nxt = div_cnt_r - DCW'(1);
        if (div_cnt_r == DCW'(1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          for (int k = 0; k < 3; k++) begin
            mean = sum_r[k][CH_W-1:0];
            ctr  = centre_r[(2-k)*CH_W +: CH_W];
            diff = (ctr > mean) ? ctr - mean : mean - ctr;
            res_nxt[k] = (mode_t'(mode_r) == MODE_EDGE) ? 8'd255 - diff : mean;
          end
          out_valid_nxt = 1'b1;
          pending_nxt   = pending_r - PW'(1);
          rd_addr_nxt   = (rd_addr_r == AW'(Depth - 1)) ? '0 : rd_addr_r + AW'(1);
          if (ocol_r == w_eff - XW'(1)) begin
            out_col_nxt = '0;
            out_row_nxt = (orow_r == h_eff - YW'(1)) ? '0 : orow_r + YW'(1);
          end else begin
            out_col_nxt = ocol_r + XW'(1);
            out_row_nxt = orow_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_row_r    <= '0;
      in_col_r    <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      rd_addr_r   <= '0;
      pending_r   <= '0;
      acc_v_r     <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      rd_addr_r   <= rd_addr_nxt;
      pending_r   <= pending_nxt;
      acc_v_r     <= acc_v_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    orow_r     <= orow_nxt;
    ocol_r     <= ocol_nxt;
    r0_r       <= r0_nxt;
    r1_r       <= r1_nxt;
    c0_r       <= c0_nxt;
    c1_r       <= c1_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    back_r     <= back_nxt;
    addr_r     <= addr_nxt;
    row_base_r <= row_base_nxt;
    centre_r   <= centre_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= last_nxt;
    for (int k = 0; k < 3; k++) begin
      sum_r[k] <= sum_nxt[k];
      rem_r[k] <= rem_nxt[k];
      res_r[k] <= res_nxt[k];
    end
  end

  // Line store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= store_mem[rd_sel];
  end

  // The frame-end flag follows the result registers.
  logic out_last_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && slot_free) begin
      out_last_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_out    = res_r[0];
  assign out_green_out  = res_r[1];
  assign out_blue_out   = res_r[2];
  assign out_frame_last = out_last_r;

  // The count of buffered pixels never passes the store depth.
  `BOXF_ASSERT_IMP(a_pending_bound, clk, rst_n, 1'b1, 32'(pending_r) <= Depth)
  // The divider never runs with an empty window.
  `BOXF_ASSERT_IMP(a_cnt_nonzero, clk, rst_n, state_r == ST_DIV, cnt_r != '0)
  // The red mean always fits in one channel.
  `BOXF_ASSERT_IMP(a_mean_range, clk, rst_n, state_r == ST_OUT, 32'(sum_r[0]) < 256)
  // A finished result reaches the output register in the next cycle.
  `BOXF_ASSERT_NEXT(a_out_load, clk, rst_n, state_r == ST_OUT && slot_free,
    out_valid_r && state_r == ST_IDLE)

endmodule
`default_nettype wire
